// File: src/rid_pkg.sv
package rid_pkg;

	typedef struct packed {
		logic [63:0] dividend;
		logic [63:0] divisor;
	} in_word_t;

	typedef struct packed {
		logic [63:0] quotient;
		logic        is_null;
		logic [1:0]  status;
	} out_word_t;

	localparam logic [1:0] MODE_TRUNC_ERR  = 2'd0;
	localparam logic [1:0] MODE_TRUNC_ZERO = 2'd1;
	localparam logic [1:0] MODE_ROUND      = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic CFG_DIV_MODE = 1'b0;
	localparam logic CFG_SIGNED   = 1'b1;

	typedef struct packed {
		logic       neg;
		logic       round;
		logic       special;
		logic [1:0] status;
		logic       is_null;
		logic       wrap;
	} ctl_t;

endpackage

// File: src/rid_prep.sv
module rid_prep #(
	parameter int W = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 vin,
	input  rid_pkg::in_word_t    din,
	input  logic [1:0]           div_mode,
	input  logic                 signed_operands,
	output logic                 v_s1,
	output logic [W-1:0]         ma_s1,
	output logic [W-1:0]         mb_s1,
	output rid_pkg::ctl_t        ctl_s1
);
	logic [W-1:0] a, b, ma, mb;
	logic na, nb, bz, ovf;
	logic [1:0] mode;
	rid_pkg::ctl_t ctl;

	always_comb begin
		a = din.dividend[W-1:0];
		b = din.divisor[W-1:0];
		mode = (div_mode == 2'd3) ? rid_pkg::MODE_TRUNC_ERR : div_mode;
		na = signed_operands & a[W-1];
		nb = signed_operands & b[W-1];
		ma = na ? -a : a;
		mb = nb ? -b : b;
		bz = (b == '0);
		ovf = signed_operands && (a == {1'b1, {(W-1){1'b0}}}) && (b == '1);
		ctl = '0;
		ctl.neg = na ^ nb;
		ctl.round = (mode == rid_pkg::MODE_ROUND);
		ctl.special = bz | ovf;
		if (bz) begin
			case (mode)
				rid_pkg::MODE_TRUNC_ERR: ctl.status = rid_pkg::ST_DIV_ZERO;
				rid_pkg::MODE_ROUND: begin
					ctl.status = rid_pkg::ST_DIV_ZERO;
					ctl.is_null = 1'b1;
				end
				default: ctl.status = rid_pkg::ST_OK;
			endcase
		end else if (ovf && mode != rid_pkg::MODE_TRUNC_ZERO) begin
			ctl.status = rid_pkg::ST_OVERFLOW;
			ctl.wrap = 1'b1;
		end
		if (bz || ovf) begin
			ma = '0;
			mb = {{(W-1){1'b0}}, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s1 <= ma;
			mb_s1 <= mb;
			ctl_s1 <= ctl;
		end
	end
endmodule

// File: src/rid_stage.sv
module rid_stage #(
	parameter int W = 64,
	parameter int BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          vin,
	input  logic [W-1:0]  rem_in,
	input  logic [W-1:0]  num_in,
	input  logic [W-1:0]  den_in,
	input  rid_pkg::ctl_t ctl_in,
	output logic          vout,
	output logic [W-1:0]  rem_out,
	output logic [W-1:0]  num_out,
	output logic [W-1:0]  den_out,
	output rid_pkg::ctl_t ctl_out
);
	logic [W:0] r;
	logic [W-1:0] n;
	logic [W:0] diff;

	always_comb begin
		r = {1'b0, rem_in};
		n = num_in;
		for (int i = 0; i < BITS; i++) begin
			r = {r[W-1:0], n[W-1]};
			n = {n[W-2:0], 1'b0};
			diff = r - {1'b0, den_in};
			if (!diff[W]) begin
				r = diff;
				n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (adv) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_out <= r[W-1:0];
			num_out <= n;
			den_out <= den_in;
			ctl_out <= ctl_in;
		end
	end
endmodule

// File: src/rid_fix.sv
module rid_fix #(
	parameter int W = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vin,
	input  logic [W-1:0]       rem_in,
	input  logic [W-1:0]       quo_in,
	input  logic [W-1:0]       den_in,
	input  rid_pkg::ctl_t      ctl_in,
	output logic               vout,
	output rid_pkg::out_word_t dout
);
	logic [W-1:0] half, q;
	rid_pkg::out_word_t w;

	always_comb begin
		half = den_in - (den_in >> 1);
		q = quo_in;
		if (ctl_in.round && rem_in >= half) begin
			q = q + 1'b1;
		end
		if (ctl_in.neg) begin
			q = -q;
		end
		w = '0;
		w.is_null = ctl_in.is_null;
		w.status = ctl_in.status;
		if (ctl_in.wrap) begin
			w.quotient[W-1] = 1'b1;
		end else if (!ctl_in.special) begin
			w.quotient[W-1:0] = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (adv) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dout <= w;
		end
	end
endmodule

// File: src/rounded_integer_divide.sv
// An accepted input word passes the prep register, the divider stages and the fix register.
// Throughput: one word per cycle unless stalled; each restoring divider stage resolves
// four quotient bits, the last LAST bits; one stall signal holds the whole pipeline.
// Reset: arst_n clears all valid bits, div_mode to 0 and signed_operands to 1.
module rounded_integer_divide #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rid_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rid_pkg::out_word_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [1:0]          cfg_data
);
	localparam int W = DATA_WIDTH;
	localparam int NS = (W + 3) / 4;
	localparam int LAST = W - 4 * (NS - 1);

	logic [1:0] div_mode_q;
	logic       signed_q;
	logic       adv;

	logic          v [NS+1];
	logic [W-1:0]  rem [NS+1];
	logic [W-1:0]  num [NS+1];
	logic [W-1:0]  den [NS+1];
	rid_pkg::ctl_t ctl [NS+1];

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_mode_q <= rid_pkg::MODE_TRUNC_ERR;
			signed_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				rid_pkg::CFG_DIV_MODE: div_mode_q <= cfg_data;
				rid_pkg::CFG_SIGNED: signed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rid_prep #(.W(W)) u_prep (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(in_valid), .din(in_data),
		.div_mode(div_mode_q), .signed_operands(signed_q),
		.v_s1(v[0]), .ma_s1(num[0]), .mb_s1(den[0]), .ctl_s1(ctl[0])
	);
	assign rem[0] = '0;

	for (genvar s = 0; s < NS; s++) begin : g_st
		rid_stage #(.W(W), .BITS((s == NS - 1) ? LAST : 4)) u_st (
			.clk(clk), .arst_n(arst_n), .adv(adv), .vin(v[s]),
			.rem_in(rem[s]), .num_in(num[s]), .den_in(den[s]), .ctl_in(ctl[s]),
			.vout(v[s+1]), .rem_out(rem[s+1]), .num_out(num[s+1]),
			.den_out(den[s+1]), .ctl_out(ctl[s+1])
		);
	end

	rid_fix #(.W(W)) u_fix (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(v[NS]),
		.rem_in(rem[NS]), .quo_in(num[NS]), .den_in(den[NS]), .ctl_in(ctl[NS]),
		.vout(out_valid), .dout(out_data)
	);
endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int LATENCY = 64 / 4 + 2;
	localparam int N_RANDOM = 1330;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rid_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rid_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [1:0] cfg_data = '0;

	logic [1:0] cur_mode;
	logic cur_signed;
	rid_pkg::out_word_t quotient_q[$];
	int errors = 0;
	bit hold_rx = 1'b0;

	typedef struct {
		logic [63:0] a;
		logic [63:0] b;
		bit typed;
		rid_pkg::out_word_t res;
	} row_t;

	rounded_integer_divide u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic rid_pkg::out_word_t divide_word(logic [63:0] a, logic [63:0] b);
		rid_pkg::out_word_t r;
		logic [1:0] m;
		logic na, nb;
		logic [63:0] ma, mb, q, rem;
		r = '0;
		m = (cur_mode == 2'd3) ? rid_pkg::MODE_TRUNC_ERR : cur_mode;
		if (b == 64'd0) begin
			if (m == rid_pkg::MODE_TRUNC_ERR) begin
				r.status = rid_pkg::ST_DIV_ZERO;
			end else if (m == rid_pkg::MODE_ROUND) begin
				r.is_null = 1'b1;
				r.status = rid_pkg::ST_DIV_ZERO;
			end
		end else if (cur_signed && a == {1'b1, 63'd0} && b == '1) begin
			if (m != rid_pkg::MODE_TRUNC_ZERO) begin
				r.quotient = {1'b1, 63'd0};
				r.status = rid_pkg::ST_OVERFLOW;
			end
		end else begin
			na = cur_signed & a[63];
			nb = cur_signed & b[63];
			ma = na ? -a : a;
			mb = nb ? -b : b;
			q = ma / mb;
			rem = ma % mb;
			if (m == rid_pkg::MODE_ROUND && rem >= mb - mb / 2)
				q = q + 64'd1;
			if (na != nb)
				q = -q;
			r.quotient = q;
		end
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic write_reg(logic idx, logic [1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == rid_pkg::CFG_DIV_MODE) cur_mode = val;
		else cur_signed = val[0];
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (quotient_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic send(logic [63:0] a, logic [63:0] b, int gap);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{dividend: a, divisor: b};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		quotient_q.push_back(divide_word(a, b));
	endtask

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		case ($urandom_range(0, 7))
			0: v = '1;
			1: v = {1'b1, 63'd0};
			2: v = 64'($urandom_range(0, 9));
			3: v = -64'($urandom_range(1, 9));
			4: v = {32'd0, 32'($urandom)};
			default: v = {32'($urandom), 32'($urandom)};
		endcase
		return v;
	endfunction

	// Output side: the checker compares each word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (quotient_q.size() == 0) begin
				report("unexpected word", out_data.quotient, 64'd0);
			end else begin
				rid_pkg::out_word_t w;
				w = quotient_q.pop_front();
				if (out_data.quotient !== w.quotient)
					report("quotient", out_data.quotient, w.quotient);
				if (out_data.is_null !== w.is_null)
					report("is_null", 64'(out_data.is_null), 64'(w.is_null));
				if (out_data.status !== w.status)
					report("status", 64'(out_data.status), 64'(w.status));
			end
		end
	end

	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
			end else begin
				n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
				if (n == 0) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					repeat (n - 1) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		logic [1:0] modes[4];
		rid_pkg::out_word_t w;
		int k;
		cur_mode = rid_pkg::MODE_TRUNC_ERR;
		cur_signed = 1'b1;
		w = '0; w.status = rid_pkg::ST_DIV_ZERO;
		rows.push_back('{64'd7, 64'd0, 1'b1, w});
		w = '0; w.quotient = {1'b1, 63'd0}; w.status = rid_pkg::ST_OVERFLOW;
		rows.push_back('{{1'b1, 63'd0}, '1, 1'b1, w});
		w = '0; w.quotient = 64'd3;
		rows.push_back('{64'd7, 64'd2, 1'b1, w});
		rows.push_back('{'1, '1, 1'b0, '0});
		rows.push_back('{'1, 64'd1, 1'b0, '0});
		rows.push_back('{64'd0, '1, 1'b0, '0});
		rows.push_back('{{1'b1, 63'd0}, 64'd1, 1'b0, '0});
		rows.push_back('{{1'b0, {63{1'b1}}}, '1, 1'b0, '0});
		rows.push_back('{-64'd7, 64'd2, 1'b0, '0});
		rows.push_back('{64'd5, 64'd10, 1'b0, '0});
		rows.push_back('{64'd4, 64'd10, 1'b0, '0});
		rows.push_back('{64'd8, 64'd3, 1'b0, '0});

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				if (divide_word(rows[i].a, rows[i].b) !== rows[i].res)
					report("table row", 64'(i), 64'd0);
			end
			send(rows[i].a, rows[i].b, 0);
		end
		drain();
		write_reg(rid_pkg::CFG_DIV_MODE, rid_pkg::MODE_ROUND);
		foreach (rows[i]) send(rows[i].a, rows[i].b, $urandom_range(0, 2));
		drain();

		// The block fills while the receiver holds off.
		hold_rx = 1'b1;
		fork
			begin
				for (int j = 0; j < 30; j++) send(rand64(), rand64(), 0);
			end
			begin
				repeat (60) @(posedge clk);
				hold_rx = 1'b0;
			end
		join
		drain();

		modes = '{rid_pkg::MODE_TRUNC_ERR, rid_pkg::MODE_TRUNC_ZERO, rid_pkg::MODE_ROUND, 2'd3};
		k = 0;
		while (k < N_RANDOM) begin
			write_reg(rid_pkg::CFG_DIV_MODE, modes[$urandom_range(0, 3)]);
			write_reg(rid_pkg::CFG_SIGNED, 2'($urandom_range(0, 1)));
			for (int j = 0; j < 150 && k < N_RANDOM; j++, k++) begin
				if ($urandom_range(0, 2) == 0)
					send(rand64(), rand64(), 0);
				else
					send(rand64(), rand64(), $urandom_range(0, 5));
			end
			drain();
		end

		if (errors == 0 && quotient_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
src/rid_pkg.sv
src/rid_prep.sv
src/rid_stage.sv
src/rid_fix.sv
src/rounded_integer_divide.sv
bench/tb.sv
